@@ src/fpgs_pkg.sv @@
// Shared types, constants and helper functions for the fuzzy PD gain scheduler.
// No dependencies; imported by the fuzzify, rules, divider and top-level modules.
`timescale 1ns / 1ps

package fpgs_pkg;

    localparam int DEF_FRAC_BITS      = 8;
    localparam int DEF_SET_HALF_WIDTH = 4;

    localparam int NUM_SETS  = 5;
    localparam int SET_IDX_W = 3;
    localparam int RULE_W    = 5;
    localparam int MAP_W     = 50;
    localparam int DATA_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int QUOT_W    = 16;

    localparam int GAIN_MAX = (1 << (DATA_W - 1)) - 1;
    localparam int GAIN_MIN = -(1 << (DATA_W - 1));

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KP_MAP   = 3'd0,
        REG_KD_MAP   = 3'd1,
        REG_KP_ZERO  = 3'd2,
        REG_KP_SMALL = 3'd3,
        REG_KP_BIG   = 3'd4,
        REG_KD_ZERO  = 3'd5,
        REG_KD_SMALL = 3'd6,
        REG_KD_BIG   = 3'd7
    } t_cfg_reg;

    // Output set codes of the rule maps; the fourth code also means the zero set.
    typedef enum logic [1:0] {
        SET_ZERO     = 2'd0,
        SET_SMALL    = 2'd1,
        SET_BIG      = 2'd2,
        SET_ZERO_ALT = 2'd3
    } t_out_set;

    typedef struct packed {
        logic signed [DATA_W-1:0] ctr_zero;
        logic signed [DATA_W-1:0] ctr_small;
        logic signed [DATA_W-1:0] ctr_big;
    } t_centers;

    localparam logic [MAP_W-1:0]         KP_MAP_RST       = 50'd1763190659153;
    localparam logic [MAP_W-1:0]         KD_MAP_RST       = 50'd77040347877476;
    localparam logic signed [DATA_W-1:0] KP_CTR_ZERO_RST  = 16'sd0;
    localparam logic signed [DATA_W-1:0] KP_CTR_SMALL_RST = 16'sd2560;
    localparam logic signed [DATA_W-1:0] KP_CTR_BIG_RST   = 16'sd5120;
    localparam logic signed [DATA_W-1:0] KD_CTR_ZERO_RST  = 16'sd0;
    localparam logic signed [DATA_W-1:0] KD_CTR_SMALL_RST = 16'sd1024;
    localparam logic signed [DATA_W-1:0] KD_CTR_BIG_RST   = 16'sd2048;

    // Membership grade width: values 0 .. (half width << frac bits)
    function automatic int mem_width(input int frac_bits, input int half_width);
        mem_width = $clog2((half_width << frac_bits) + 1);
    endfunction

    // Total rule strength never exceeds twice the scaled set half width
    function automatic int den_width(input int frac_bits, input int half_width);
        den_width = $clog2(2 * (half_width << frac_bits) + 1);
    endfunction

    // Sum of four strength * center products, signed
    function automatic int num_width(input int frac_bits, input int half_width);
        num_width = mem_width(frac_bits, half_width) + 1 + DATA_W + 2;
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_center(
        input logic [MAP_W-1:0]  map,
        input logic [RULE_W-1:0] rule,
        input t_centers          ctr
    );
        logic [1:0] code;
        code = map[2 * rule +: 2];
        case (t_out_set'(code))
            SET_ZERO:     pick_center = ctr.ctr_zero;
            SET_SMALL:    pick_center = ctr.ctr_small;
            SET_BIG:      pick_center = ctr.ctr_big;
            SET_ZERO_ALT: pick_center = ctr.ctr_zero;
            default:      pick_center = ctr.ctr_zero;
        endcase
    endfunction

endpackage

@@ src/fpgs_fuzzify.sv @@
// Two-stage fuzzifier: grades both inputs against the five triangular sets,
// then keeps the (at most two) adjacent sets that fire. Uses fpgs_pkg.
`timescale 1ns / 1ps

module fpgs_fuzzify #(
    parameter int FRAC_BITS      = fpgs_pkg::DEF_FRAC_BITS,
    parameter int SET_HALF_WIDTH = fpgs_pkg::DEF_SET_HALF_WIDTH
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic signed [fpgs_pkg::DATA_W-1:0]     i_error_value,
    input  logic signed [fpgs_pkg::DATA_W-1:0]     i_error_rate,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic [1:0][fpgs_pkg::SET_IDX_W-1:0]    o_err_idx,
    output logic [1:0][fpgs_pkg::SET_IDX_W-1:0]    o_rate_idx,
    output logic [1:0][fpgs_pkg::mem_width(FRAC_BITS, SET_HALF_WIDTH)-1:0] o_err_grade,
    output logic [1:0][fpgs_pkg::mem_width(FRAC_BITS, SET_HALF_WIDTH)-1:0] o_rate_grade
);
    import fpgs_pkg::*;

    localparam int W     = SET_HALF_WIDTH << FRAC_BITS;
    localparam int MEM_W = mem_width(FRAC_BITS, SET_HALF_WIDTH);
    localparam int XW    = (MEM_W + 3 > DATA_W + 2) ? MEM_W + 3 : DATA_W + 2;

    typedef logic [NUM_SETS-1:0][MEM_W-1:0] t_grades;
    typedef struct packed {
        logic [1:0][SET_IDX_W-1:0] idx;
        logic [1:0][MEM_W-1:0]     grade;
    } t_pair;

    function automatic t_grades grade_all(input logic signed [DATA_W-1:0] x);
        logic signed [XW-1:0] delta;
        logic [XW-1:0]        mag;
        t_grades              g;
        for (int k = 0; k < NUM_SETS; k++) begin
            delta = XW'(x) - XW'((k - 2) * W);
            mag   = (delta < 0) ? XW'(-delta) : XW'(delta);
            g[k]  = (mag < XW'(W)) ? MEM_W'(XW'(W) - mag) : '0;
        end
        return g;
    endfunction

    // Lowest firing set and its right neighbor; no other set can fire.
    function automatic t_pair pick_pair(input t_grades g);
        t_grades nxt;
        t_pair   p;
        logic    found;
        nxt = '0;
        for (int k = 0; k < NUM_SETS - 1; k++) begin
            nxt[k] = g[k + 1];
        end
        p     = '0;
        found = 1'b0;
        for (int k = 0; k < NUM_SETS; k++) begin
            if (!found && g[k] != '0) begin
                found      = 1'b1;
                p.idx[0]   = SET_IDX_W'(k);
                p.idx[1]   = (k == NUM_SETS - 1) ? SET_IDX_W'(k) : SET_IDX_W'(k + 1);
                p.grade[0] = g[k];
                p.grade[1] = nxt[k];
            end
        end
        return p;
    endfunction

    logic    r_v1, r_v2;
    logic    en1, en2;
    t_grades r_err_g, r_rate_g;
    t_pair   r_err_p, r_rate_p;

    assign en2     = !r_v2 || i_ready;
    assign en1     = !r_v1 || en2;
    assign o_ready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_err_g  <= grade_all(i_error_value);
            r_rate_g <= grade_all(i_error_rate);
        end
        if (en2) begin
            r_err_p  <= pick_pair(r_err_g);
            r_rate_p <= pick_pair(r_rate_g);
        end
    end

    assign o_valid      = r_v2;
    assign o_err_idx    = r_err_p.idx;
    assign o_err_grade  = r_err_p.grade;
    assign o_rate_idx   = r_rate_p.idx;
    assign o_rate_grade = r_rate_p.grade;

endmodule

@@ src/fpgs_rules.sv @@
// Three-stage rule evaluation: strengths and centers of the four candidate
// rules, strength * center products, then the weighted sums. Uses fpgs_pkg.
`timescale 1ns / 1ps

module fpgs_rules #(
    parameter int FRAC_BITS      = fpgs_pkg::DEF_FRAC_BITS,
    parameter int SET_HALF_WIDTH = fpgs_pkg::DEF_SET_HALF_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [1:0][fpgs_pkg::SET_IDX_W-1:0] i_err_idx,
    input  logic [1:0][fpgs_pkg::SET_IDX_W-1:0] i_rate_idx,
    input  logic [1:0][fpgs_pkg::mem_width(FRAC_BITS, SET_HALF_WIDTH)-1:0] i_err_grade,
    input  logic [1:0][fpgs_pkg::mem_width(FRAC_BITS, SET_HALF_WIDTH)-1:0] i_rate_grade,
    input  logic [fpgs_pkg::MAP_W-1:0]          i_kp_map,
    input  logic [fpgs_pkg::MAP_W-1:0]          i_kd_map,
    input  fpgs_pkg::t_centers                  i_kp_ctr,
    input  fpgs_pkg::t_centers                  i_kd_ctr,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [fpgs_pkg::den_width(FRAC_BITS, SET_HALF_WIDTH)-1:0] o_sum_s,
    output logic signed [fpgs_pkg::num_width(FRAC_BITS, SET_HALF_WIDTH)-1:0] o_sum_kp,
    output logic signed [fpgs_pkg::num_width(FRAC_BITS, SET_HALF_WIDTH)-1:0] o_sum_kd
);
    import fpgs_pkg::*;

    localparam int MEM_W = mem_width(FRAC_BITS, SET_HALF_WIDTH);
    localparam int SW    = den_width(FRAC_BITS, SET_HALF_WIDTH);
    localparam int SPW   = num_width(FRAC_BITS, SET_HALF_WIDTH);
    localparam int PW    = MEM_W + 1 + DATA_W;
    localparam int NQ    = 4;

    logic r_va, r_vb, r_vc;
    logic en_a, en_b, en_c;

    logic [MEM_W-1:0]         n_str [NQ];
    logic signed [DATA_W-1:0] n_kp_c [NQ];
    logic signed [DATA_W-1:0] n_kd_c [NQ];
    logic [MEM_W-1:0]         r_str [NQ];
    logic signed [DATA_W-1:0] r_kp_c [NQ];
    logic signed [DATA_W-1:0] r_kd_c [NQ];
    logic signed [PW-1:0]     r_prod_kp [NQ];
    logic signed [PW-1:0]     r_prod_kd [NQ];
    logic [SW-1:0]            r_sum_s_b, r_sum_s;
    logic signed [SPW-1:0]    r_sum_kp, r_sum_kd;

    assign en_c    = !r_vc || i_ready;
    assign en_b    = !r_vb || en_c;
    assign en_a    = !r_va || en_b;
    assign o_ready = en_a;

    // Candidate rule q pairs error set q[1] with rate set q[0]
    always_comb begin
        logic [RULE_W-1:0] rule;
        logic [MEM_W-1:0]  ge, gr;
        for (int q = 0; q < NQ; q++) begin
            ge        = i_err_grade[q >> 1];
            gr        = i_rate_grade[q & 1];
            n_str[q]  = (ge < gr) ? ge : gr;
            rule      = RULE_W'(i_err_idx[q >> 1]) * RULE_W'(NUM_SETS)
                      + RULE_W'(i_rate_idx[q & 1]);
            n_kp_c[q] = pick_center(i_kp_map, rule, i_kp_ctr);
            n_kd_c[q] = pick_center(i_kd_map, rule, i_kd_ctr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else begin
            if (en_a) r_va <= i_valid;
            if (en_b) r_vb <= r_va;
            if (en_c) r_vc <= r_vb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a) begin
            for (int q = 0; q < NQ; q++) begin
                r_str[q]  <= n_str[q];
                r_kp_c[q] <= n_kp_c[q];
                r_kd_c[q] <= n_kd_c[q];
            end
        end
        if (en_b) begin
            for (int q = 0; q < NQ; q++) begin
                r_prod_kp[q] <= $signed({1'b0, r_str[q]}) * r_kp_c[q];
                r_prod_kd[q] <= $signed({1'b0, r_str[q]}) * r_kd_c[q];
            end
            r_sum_s_b <= SW'(r_str[0]) + SW'(r_str[1]) + SW'(r_str[2]) + SW'(r_str[3]);
        end
        if (en_c) begin
            r_sum_kp <= SPW'(r_prod_kp[0]) + SPW'(r_prod_kp[1])
                      + SPW'(r_prod_kp[2]) + SPW'(r_prod_kp[3]);
            r_sum_kd <= SPW'(r_prod_kd[0]) + SPW'(r_prod_kd[1])
                      + SPW'(r_prod_kd[2]) + SPW'(r_prod_kd[3]);
            r_sum_s  <= r_sum_s_b;
        end
    end

    assign o_valid  = r_vc;
    assign o_sum_s  = r_sum_s;
    assign o_sum_kp = r_sum_kp;
    assign o_sum_kd = r_sum_kd;

endmodule

@@ src/fpgs_divider.sv @@
// Pipelined rounding divider for both gains: operand prep, one quotient bit
// per stage (restoring), then sign, zero-strength override and clamp. Uses fpgs_pkg.
`timescale 1ns / 1ps

module fpgs_divider #(
    parameter int FRAC_BITS      = fpgs_pkg::DEF_FRAC_BITS,
    parameter int SET_HALF_WIDTH = fpgs_pkg::DEF_SET_HALF_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [fpgs_pkg::den_width(FRAC_BITS, SET_HALF_WIDTH)-1:0] i_sum_s,
    input  logic signed [fpgs_pkg::num_width(FRAC_BITS, SET_HALF_WIDTH)-1:0] i_sum_kp,
    input  logic signed [fpgs_pkg::num_width(FRAC_BITS, SET_HALF_WIDTH)-1:0] i_sum_kd,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [fpgs_pkg::DATA_W-1:0]  o_kp_gain,
    output logic signed [fpgs_pkg::DATA_W-1:0]  o_kd_gain,
    output logic                                o_no_rule_fired
);
    import fpgs_pkg::*;

    localparam int SW   = den_width(FRAC_BITS, SET_HALF_WIDTH);
    localparam int SPW  = num_width(FRAC_BITS, SET_HALF_WIDTH);
    localparam int NW   = SPW + 1;
    localparam int DW   = SW + 1;
    localparam int LAST = QUOT_W + 1;
    localparam int VW   = QUOT_W + 2;

    logic r_v [0:LAST];
    logic en  [0:LAST];

    logic [NW-1:0]     r_rem_kp [0:QUOT_W];
    logic [NW-1:0]     r_rem_kd [0:QUOT_W];
    logic [QUOT_W-1:0] r_q_kp   [0:QUOT_W];
    logic [QUOT_W-1:0] r_q_kd   [0:QUOT_W];
    logic [DW-1:0]     r_div    [0:QUOT_W];
    logic              r_neg_kp [0:QUOT_W];
    logic              r_neg_kd [0:QUOT_W];
    logic              r_none   [0:QUOT_W];

    logic signed [DATA_W-1:0] r_kp_gain, r_kd_gain;
    logic                     r_no_rule;

    logic [SPW-1:0] mag_kp, mag_kd;

    // round(num / den) = floor((2|num| + den) / (2 den)), sign applied after
    function automatic logic signed [DATA_W-1:0] finish(
        input logic [QUOT_W-1:0] q,
        input logic              neg,
        input logic              none
    );
        logic signed [VW-1:0] v;
        v = $signed({2'b00, q});
        if (neg) v = -v;
        if (none) begin
            finish = '0;
        end else if (v > VW'(GAIN_MAX)) begin
            finish = DATA_W'(GAIN_MAX);
        end else if (v < VW'(GAIN_MIN)) begin
            finish = DATA_W'(GAIN_MIN);
        end else begin
            finish = DATA_W'(v);
        end
    endfunction

    assign en[LAST] = !r_v[LAST] || i_ready;
    assign o_ready  = en[0];

    generate
        for (genvar s = 0; s < LAST; s++) begin : g_en
            assign en[s] = !r_v[s] || en[s + 1];
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= LAST; s++) r_v[s] <= 1'b0;
        end else begin
            if (en[0]) r_v[0] <= i_valid;
            for (int s = 1; s <= LAST; s++) begin
                if (en[s]) r_v[s] <= r_v[s - 1];
            end
        end
    end

    assign mag_kp = i_sum_kp[SPW-1] ? SPW'(-i_sum_kp) : SPW'(i_sum_kp);
    assign mag_kd = i_sum_kd[SPW-1] ? SPW'(-i_sum_kd) : SPW'(i_sum_kd);

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_rem_kp[0] <= {mag_kp, 1'b0} + NW'(i_sum_s);
            r_rem_kd[0] <= {mag_kd, 1'b0} + NW'(i_sum_s);
            r_q_kp[0]   <= '0;
            r_q_kd[0]   <= '0;
            r_div[0]    <= {i_sum_s, 1'b0};
            r_neg_kp[0] <= i_sum_kp[SPW-1];
            r_neg_kd[0] <= i_sum_kd[SPW-1];
            r_none[0]   <= (i_sum_s == '0);
        end
    end

    generate
        for (genvar s = 1; s <= QUOT_W; s++) begin : g_bit
            localparam int K = QUOT_W - s;
            logic fits_kp, fits_kd;

            assign fits_kp = (r_rem_kp[s-1] >> K) >= NW'(r_div[s-1]);
            assign fits_kd = (r_rem_kd[s-1] >> K) >= NW'(r_div[s-1]);

            always_ff @(posedge i_clk) begin
                if (en[s]) begin
                    r_rem_kp[s] <= fits_kp ? r_rem_kp[s-1] - (NW'(r_div[s-1]) << K)
                                           : r_rem_kp[s-1];
                    r_rem_kd[s] <= fits_kd ? r_rem_kd[s-1] - (NW'(r_div[s-1]) << K)
                                           : r_rem_kd[s-1];
                    r_q_kp[s]   <= {r_q_kp[s-1][QUOT_W-2:0], fits_kp};
                    r_q_kd[s]   <= {r_q_kd[s-1][QUOT_W-2:0], fits_kd};
                    r_div[s]    <= r_div[s-1];
                    r_neg_kp[s] <= r_neg_kp[s-1];
                    r_neg_kd[s] <= r_neg_kd[s-1];
                    r_none[s]   <= r_none[s-1];
                end
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (en[LAST]) begin
            r_kp_gain <= finish(r_q_kp[QUOT_W], r_neg_kp[QUOT_W], r_none[QUOT_W]);
            r_kd_gain <= finish(r_q_kd[QUOT_W], r_neg_kd[QUOT_W], r_none[QUOT_W]);
            r_no_rule <= r_none[QUOT_W];
        end
    end

    assign o_valid         = r_v[LAST];
    assign o_kp_gain       = r_kp_gain;
    assign o_kd_gain       = r_kd_gain;
    assign o_no_rule_fired = r_no_rule;

endmodule

@@ src/fuzzy_pd_gain_scheduler_unit.sv @@
// Top level of the fuzzy PD gain scheduler: configuration registers and the
// fuzzify -> rules -> divider pipeline. Depends on fpgs_pkg, fpgs_fuzzify, fpgs_rules and fpgs_divider.
`timescale 1ns / 1ps

// Channel  Dir   Handshake                   Payload
// in       sink  i_in_valid / o_in_stall     i_error_value, i_error_rate
// out      src   o_out_valid / i_out_stall   o_kp_gain, o_kd_gain, o_no_rule_fired
// cfg      sink  i_cfg_wr_en                 i_cfg_index, i_cfg_wr_data
//
// One transaction per cycle sustained while the output is not stalled; the result
// passes 23 register stages: 2 fuzzify, 3 rule, 18 divider (operand prep, 16
// quotient bits at one bit per stage, result). The 16-bit quotient pipeline sets
// the latency. Synchronous active-low reset clears all stage valids and loads the
// register defaults. A stage holds only while the stage after it is full, so
// bubbles close up and input keeps flowing under stall until every stage is full.

module fuzzy_pd_gain_scheduler_unit #(
    parameter int FRAC_BITS      = fpgs_pkg::DEF_FRAC_BITS,
    parameter int SET_HALF_WIDTH = fpgs_pkg::DEF_SET_HALF_WIDTH
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic signed [fpgs_pkg::DATA_W-1:0]   i_error_value,
    input  logic signed [fpgs_pkg::DATA_W-1:0]   i_error_rate,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [fpgs_pkg::DATA_W-1:0]   o_kp_gain,
    output logic signed [fpgs_pkg::DATA_W-1:0]   o_kd_gain,
    output logic                                 o_no_rule_fired,
    input  logic                                 i_cfg_wr_en,
    input  logic [fpgs_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [fpgs_pkg::MAP_W-1:0]           i_cfg_wr_data
);
    import fpgs_pkg::*;

    localparam int MEM_W = mem_width(FRAC_BITS, SET_HALF_WIDTH);
    localparam int SW    = den_width(FRAC_BITS, SET_HALF_WIDTH);
    localparam int SPW   = num_width(FRAC_BITS, SET_HALF_WIDTH);

    logic [MAP_W-1:0] r_kp_map, r_kd_map;
    t_centers         r_kp_ctr, r_kd_ctr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp_map <= KP_MAP_RST;
            r_kd_map <= KD_MAP_RST;
            r_kp_ctr <= '{ctr_zero: KP_CTR_ZERO_RST, ctr_small: KP_CTR_SMALL_RST,
                          ctr_big: KP_CTR_BIG_RST};
            r_kd_ctr <= '{ctr_zero: KD_CTR_ZERO_RST, ctr_small: KD_CTR_SMALL_RST,
                          ctr_big: KD_CTR_BIG_RST};
        end else if (i_cfg_wr_en) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_KP_MAP:   r_kp_map           <= i_cfg_wr_data;
                REG_KD_MAP:   r_kd_map           <= i_cfg_wr_data;
                REG_KP_ZERO:  r_kp_ctr.ctr_zero  <= $signed(i_cfg_wr_data[DATA_W-1:0]);
                REG_KP_SMALL: r_kp_ctr.ctr_small <= $signed(i_cfg_wr_data[DATA_W-1:0]);
                REG_KP_BIG:   r_kp_ctr.ctr_big   <= $signed(i_cfg_wr_data[DATA_W-1:0]);
                REG_KD_ZERO:  r_kd_ctr.ctr_zero  <= $signed(i_cfg_wr_data[DATA_W-1:0]);
                REG_KD_SMALL: r_kd_ctr.ctr_small <= $signed(i_cfg_wr_data[DATA_W-1:0]);
                REG_KD_BIG:   r_kd_ctr.ctr_big   <= $signed(i_cfg_wr_data[DATA_W-1:0]);
                default: ;
            endcase
        end
    end

    logic                          fz_ready, fz_valid;
    logic [1:0][SET_IDX_W-1:0]     fz_err_idx, fz_rate_idx;
    logic [1:0][MEM_W-1:0]         fz_err_grade, fz_rate_grade;
    logic                          rl_ready, rl_valid;
    logic [SW-1:0]                 rl_sum_s;
    logic signed [SPW-1:0]         rl_sum_kp, rl_sum_kd;
    logic                          dv_ready;

    fpgs_fuzzify #(
        .FRAC_BITS      (FRAC_BITS),
        .SET_HALF_WIDTH (SET_HALF_WIDTH)
    ) u_fuzzify (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_in_valid),
        .o_ready       (fz_ready),
        .i_error_value (i_error_value),
        .i_error_rate  (i_error_rate),
        .o_valid       (fz_valid),
        .i_ready       (rl_ready),
        .o_err_idx     (fz_err_idx),
        .o_rate_idx    (fz_rate_idx),
        .o_err_grade   (fz_err_grade),
        .o_rate_grade  (fz_rate_grade)
    );

    fpgs_rules #(
        .FRAC_BITS      (FRAC_BITS),
        .SET_HALF_WIDTH (SET_HALF_WIDTH)
    ) u_rules (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (fz_valid),
        .o_ready      (rl_ready),
        .i_err_idx    (fz_err_idx),
        .i_rate_idx   (fz_rate_idx),
        .i_err_grade  (fz_err_grade),
        .i_rate_grade (fz_rate_grade),
        .i_kp_map     (r_kp_map),
        .i_kd_map     (r_kd_map),
        .i_kp_ctr     (r_kp_ctr),
        .i_kd_ctr     (r_kd_ctr),
        .o_valid      (rl_valid),
        .i_ready      (dv_ready),
        .o_sum_s      (rl_sum_s),
        .o_sum_kp     (rl_sum_kp),
        .o_sum_kd     (rl_sum_kd)
    );

    fpgs_divider #(
        .FRAC_BITS      (FRAC_BITS),
        .SET_HALF_WIDTH (SET_HALF_WIDTH)
    ) u_divider (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (rl_valid),
        .o_ready         (dv_ready),
        .i_sum_s         (rl_sum_s),
        .i_sum_kp        (rl_sum_kp),
        .i_sum_kd        (rl_sum_kd),
        .o_valid         (o_out_valid),
        .i_ready         (!i_out_stall),
        .o_kp_gain       (o_kp_gain),
        .o_kd_gain       (o_kd_gain),
        .o_no_rule_fired (o_no_rule_fired)
    );

    assign o_in_stall = !fz_ready;

endmodule

@@ src/fpgs_port_chk.sv @@
// Port-level checks for the fuzzy PD gain scheduler and the bind that
// attaches them to fuzzy_pd_gain_scheduler_unit. No package dependency.
`timescale 1ns / 1ps

module fpgs_port_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic [15:0] i_error_value,
    input logic [15:0] i_error_rate,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [15:0] o_kp_gain,
    input logic [15:0] o_kd_gain,
    input logic        o_no_rule_fired
);

    a_in_data_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=>
            i_in_valid && $stable(i_error_value) && $stable(i_error_rate))
        else $error("input transaction changed while stalled");

    a_out_valid_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output valid dropped while stalled");

    a_out_data_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            $stable(o_kp_gain) && $stable(o_kd_gain) && $stable(o_no_rule_fired))
        else $error("output transaction changed while stalled");

    a_no_rule_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_no_rule_fired |-> o_kp_gain == 16'd0 && o_kd_gain == 16'd0)
        else $error("gains nonzero with no rule fired");

    // Input may only back up once the whole pipe is full behind a stalled output
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled with room in the pipeline");

endmodule

bind fuzzy_pd_gain_scheduler_unit fpgs_port_chk u_port_chk (.*);
